/* rtl/gdlw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gdlw_pkg;

    localparam int MAX_STEPS  = 9;
    localparam int COORD_BITS = 16;
    localparam int POS_W      = COORD_BITS + 2;
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);
    localparam int DIR_W      = 8;
    localparam int CNT_W      = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_HEX_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] MAP_W_RESET = 16'd256;
    localparam logic [CFG_DATA_W-1:0] MAP_H_RESET = 16'd256;

    // commands from controller to datapath
    typedef struct packed {
        logic load_start;   // take start coordinates from the input word
        logic load_dir;     // latch direction of the accepted pair
        logic step;         // move one cell and register a result
        logic last;         // this step closes the pair
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic pair_ok;      // direction and step count both in range
        logic out_free;     // output register can take a new word
    } t_sts;

endpackage

`default_nettype wire

/* rtl/gdlw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module gdlw_ctrl
    import gdlw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_begin_req,
    input  wire logic [CNT_W-1:0] i_step_count,
    input  wire t_sts             i_sts,
    output logic                  o_in_ready,
    output t_cmd                  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic              r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              w_acc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    o_cmd.load_start = i_begin_req;
                    o_cmd.load_dir   = 1'b1;
                    if (i_sts.pair_ok) begin
                        n_cnt   = i_step_count[STEP_W-1:0];
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    o_cmd.last = (r_cnt == STEP_W'(1));
                    n_cnt      = r_cnt - STEP_W'(1);
                    if (o_cmd.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* rtl/gdlw_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module gdlw_dp
    import gdlw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [DIR_W-1:0]      i_direction,
    input  wire logic [CNT_W-1:0]      i_step_count,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [COORD_BITS-1:0]      o_pos_x,
    output logic [COORD_BITS-1:0]      o_pos_y,
    output logic                       o_on_map,
    output logic                       o_last_step
);

    // hex directions, y grows downwards
    localparam logic [2:0] HX_XN_EVEN = 3'd0;  // x-1, y-1 if new x even
    localparam logic [2:0] HX_XN_ODD  = 3'd1;  // x-1, y+1 if new x odd
    localparam logic [2:0] HX_YP      = 3'd2;
    localparam logic [2:0] HX_XP_ODD  = 3'd3;  // x+1, y+1 if new x odd
    localparam logic [2:0] HX_XP_EVEN = 3'd4;  // x+1, y-1 if new x even
    localparam logic [2:0] HX_YN      = 3'd5;
    // square directions
    localparam logic [2:0] SQ_XN      = 3'd0;
    localparam logic [2:0] SQ_XN_YP   = 3'd1;
    localparam logic [2:0] SQ_YP      = 3'd2;
    localparam logic [2:0] SQ_XP_YP   = 3'd3;
    localparam logic [2:0] SQ_XP      = 3'd4;
    localparam logic [2:0] SQ_XP_YN   = 3'd5;
    localparam logic [2:0] SQ_YN      = 3'd6;
    localparam logic [2:0] SQ_XN_YN   = 3'd7;

    localparam logic [DIR_W-1:0] HEX_DIRS = 8'd6;
    localparam logic [DIR_W-1:0] SQ_DIRS  = 8'd8;

    logic                  r_hex_mode;
    logic [CFG_DATA_W-1:0] r_map_w, r_map_h;
    logic [POS_W-1:0]      r_cur_x, r_cur_y;
    logic [2:0]            r_dir;
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_pos_x, r_pos_y;
    logic                  r_on_map, r_last;

    logic             w_xi, w_xd, w_yi, w_yd, w_np;
    logic [POS_W-1:0] n_cur_x, n_cur_y;
    logic             w_on_map, w_dir_ok, w_cnt_ok;

    // range check of the pair on the input word
    assign w_dir_ok      = i_direction < (r_hex_mode ? HEX_DIRS : SQ_DIRS);
    assign w_cnt_ok      = (i_step_count != '0) && (i_step_count <= CNT_W'(MAX_STEPS));
    assign o_sts.pair_ok = w_dir_ok && w_cnt_ok;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // one cell move; parity of x after a horizontal move is the inverse of now
    assign w_np = ~r_cur_x[0];
    always_comb begin
        w_xi = 1'b0;
        w_xd = 1'b0;
        w_yi = 1'b0;
        w_yd = 1'b0;
        if (r_hex_mode) begin
            case (r_dir)
                HX_XN_EVEN: begin w_xd = 1'b1; w_yd = ~w_np; end
                HX_XN_ODD:  begin w_xd = 1'b1; w_yi = w_np;  end
                HX_YP:      begin w_yi = 1'b1;               end
                HX_XP_ODD:  begin w_xi = 1'b1; w_yi = w_np;  end
                HX_XP_EVEN: begin w_xi = 1'b1; w_yd = ~w_np; end
                HX_YN:      begin w_yd = 1'b1;               end
                default:    begin end
            endcase
        end else begin
            case (r_dir)
                SQ_XN:    begin w_xd = 1'b1;              end
                SQ_XN_YP: begin w_xd = 1'b1; w_yi = 1'b1; end
                SQ_YP:    begin w_yi = 1'b1;              end
                SQ_XP_YP: begin w_xi = 1'b1; w_yi = 1'b1; end
                SQ_XP:    begin w_xi = 1'b1;              end
                SQ_XP_YN: begin w_xi = 1'b1; w_yd = 1'b1; end
                SQ_YN:    begin w_yd = 1'b1;              end
                SQ_XN_YN: begin w_xd = 1'b1; w_yd = 1'b1; end
                default:  begin end
            endcase
        end
    end

    assign n_cur_x = w_xi ? r_cur_x + POS_W'(1) : (w_xd ? r_cur_x - POS_W'(1) : r_cur_x);
    assign n_cur_y = w_yi ? r_cur_y + POS_W'(1) : (w_yd ? r_cur_y - POS_W'(1) : r_cur_y);

    // signed position against unsigned map size
    assign w_on_map = !n_cur_x[POS_W-1] && (n_cur_x[POS_W-2:0] < {1'b0, r_map_w})
                   && !n_cur_y[POS_W-1] && (n_cur_y[POS_W-2:0] < {1'b0, r_map_h});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_mode  <= 1'b1;
            r_map_w     <= MAP_W_RESET;
            r_map_h     <= MAP_H_RESET;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HEX_MODE:   r_hex_mode <= i_cfg_data[0];
                    REG_MAP_WIDTH:  r_map_w    <= i_cfg_data;
                    REG_MAP_HEIGHT: r_map_h    <= i_cfg_data;
                    default:        begin end
                endcase
            end
            if (i_cmd.load_start) begin
                r_cur_x <= {2'b00, i_start_x};
                r_cur_y <= {2'b00, i_start_y};
            end else if (i_cmd.step) begin
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_dir) begin
            r_dir <= i_direction[2:0];
        end
        if (i_cmd.step) begin
            r_pos_x  <= n_cur_x[COORD_BITS-1:0];
            r_pos_y  <= n_cur_y[COORD_BITS-1:0];
            r_on_map <= w_on_map;
            r_last   <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_on_map    = r_on_map;
    assign o_last_step = r_last;

endmodule

`default_nettype wire

/* rtl/grid_direction_line_walker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Walk: an accepted valid pair moves the controller to its walk state; each step
//   there registers one result word, one grid step per cycle while the output
//   register is free, set by the single step unit; an invalid pair gives no word.
// Reset: synchronous, active low; position 0,0, hex mode, 256 x 256 map,
//   output register empty.
module grid_direction_line_walker
    import gdlw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // pair stream in
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [47:0]           s_axis_tdata,  // start_x, start_y, direction, step_count
    input  wire logic                  s_axis_tuser,  // begin_req
    // position stream out
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [31:0]                m_axis_tdata,  // pos_x, pos_y
    output logic                       m_axis_tuser,  // on_map
    output logic                       m_axis_tlast   // last_step
);

    t_cmd w_cmd;
    t_sts w_sts;

    logic [COORD_BITS-1:0] w_start_x, w_start_y, w_pos_x, w_pos_y;
    logic [DIR_W-1:0]      w_direction;
    logic [CNT_W-1:0]      w_step_count;

    // unpack the input word
    assign w_start_x    = s_axis_tdata[15:0];
    assign w_start_y    = s_axis_tdata[31:16];
    assign w_direction  = s_axis_tdata[39:32];
    assign w_step_count = s_axis_tdata[47:40];

    // controller: takes one pair, then counts the steps down
    gdlw_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_begin_req  (s_axis_tuser),
        .i_step_count (w_step_count),
        .i_sts        (w_sts),
        .o_in_ready   (s_axis_tready),
        .o_cmd        (w_cmd)
    );

    // datapath: config registers, position, step unit, output register
    gdlw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_start_x    (w_start_x),
        .i_start_y    (w_start_y),
        .i_direction  (w_direction),
        .i_step_count (w_step_count),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_pos_x      (w_pos_x),
        .o_pos_y      (w_pos_y),
        .o_on_map     (m_axis_tuser),
        .o_last_step  (m_axis_tlast)
    );

    // pack the output word
    assign m_axis_tdata = {w_pos_y, w_pos_x};

    // a step never overwrites a word still waiting downstream
    a_step_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> w_sts.out_free)
        else $error("step issued while output register is held");

    // start coordinates load only on an accepted word
    a_load_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_start |-> (s_axis_tvalid && s_axis_tready))
        else $error("position reload without accepted word");

    // a new result only appears while the input side is closed
    a_out_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result word raised outside a walk");

endmodule

`default_nettype wire
